FILE: hw/rtl/ritt_pkg.sv
// Shared types, constants and microcode program of the radix integer-to-text converter.
`timescale 1ns / 1ps

package ritt_pkg;

    localparam int DIGIT_BITS = 4;
    localparam int STEP_BITS  = 8;   // dividend bits retired per division cycle
    localparam int PC_W       = 4;

    localparam logic [PC_W-1:0] ST_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] ST_CHECK = 4'd1;
    localparam logic [PC_W-1:0] ST_DIVI  = 4'd2;
    localparam logic [PC_W-1:0] ST_DIVS  = 4'd3;
    localparam logic [PC_W-1:0] ST_STORE = 4'd4;
    localparam logic [PC_W-1:0] ST_READ  = 4'd5;
    localparam logic [PC_W-1:0] ST_EMIT  = 4'd6;
    localparam logic [PC_W-1:0] ST_LOOP  = 4'd7;
    localparam logic [PC_W-1:0] ST_DONE  = 4'd8;
    localparam logic [PC_W-1:0] ST_ERR   = 4'd9;
    localparam logic [PC_W-1:0] ST_EXIT  = 4'd10;

    localparam logic [4:0] BASE_MIN = 5'd2;
    localparam logic [4:0] BASE_MAX = 5'd16;

    typedef enum logic [2:0] {
        COND_NEXT      = 3'd0,
        COND_ALWAYS    = 3'd1,
        COND_NO_REQ    = 3'd2,
        COND_BAD_BASE  = 3'd3,
        COND_DIV_MORE  = 3'd4,
        COND_MAG_NZ    = 3'd5,
        COND_SLOT_BUSY = 3'd6,
        COND_MORE_CHAR = 3'd7
    } cond_t;

    typedef struct packed {
        logic            accept;
        logic            div_init;
        logic            div_step;
        logic            store;
        logic            emit;
        logic            err;
        cond_t           cond;
        logic [PC_W-1:0] target;
    } ucode_t;

    function automatic ucode_t ucode(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '{accept: 1'b0, div_init: 1'b0, div_step: 1'b0, store: 1'b0,
              emit: 1'b0, err: 1'b0, cond: COND_ALWAYS, target: ST_IDLE};
        case (pc)
            ST_IDLE:
            begin
                w.accept = 1'b1;
                w.cond   = COND_NO_REQ;
                w.target = ST_IDLE;
            end
            ST_CHECK:
            begin
                w.cond   = COND_BAD_BASE;
                w.target = ST_ERR;
            end
            ST_DIVI:
            begin
                w.div_init = 1'b1;
                w.cond     = COND_NEXT;
            end
            ST_DIVS:
            begin
                w.div_step = 1'b1;
                w.cond     = COND_DIV_MORE;
                w.target   = ST_DIVS;
            end
            ST_STORE:
            begin
                w.store  = 1'b1;
                w.cond   = COND_MAG_NZ;
                w.target = ST_DIVI;
            end
            ST_READ:
            begin
                w.cond = COND_NEXT;
            end
            ST_EMIT:
            begin
                w.emit   = 1'b1;
                w.cond   = COND_SLOT_BUSY;
                w.target = ST_EMIT;
            end
            ST_LOOP:
            begin
                w.cond   = COND_MORE_CHAR;
                w.target = ST_READ;
            end
            ST_DONE:
            begin
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
            ST_ERR:
            begin
                w.err    = 1'b1;
                w.cond   = COND_SLOT_BUSY;
                w.target = ST_ERR;
            end
            ST_EXIT:
            begin
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
            default:
            begin
                w.cond   = COND_ALWAYS;
                w.target = ST_IDLE;
            end
        endcase
        return w;
    endfunction

    function automatic logic [7:0] digit_char(input logic [DIGIT_BITS-1:0] d, input logic lower);
        logic [7:0] c;
        if (d < 4'd10)
            c = 8'h30 + {4'd0, d};
        else if (lower)
            c = 8'h61 + {4'd0, d} - 8'd10;
        else
            c = 8'h41 + {4'd0, d} - 8'd10;
        return c;
    endfunction

endpackage

FILE: hw/rtl/ritt_in_if.sv
// Request channel: value, base and format bits with valid/ready.
`timescale 1ns / 1ps

interface ritt_in_if;
    logic        valid;
    logic        ready;
    logic [63:0] value;
    logic [4:0]  base;
    logic [1:0]  format_bits;

    modport source (output valid, output value, output base, output format_bits, input ready);
    modport sink   (input valid, input value, input base, input format_bits, output ready);
endinterface

FILE: hw/rtl/ritt_out_if.sv
// Result channel: one character with its flags, valid/ready.
`timescale 1ns / 1ps

interface ritt_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] character;
    logic       negative;
    logic       base_error;
    logic       last;

    modport source (output valid, output character, output negative, output base_error,
                    output last, input ready);
    modport sink   (input valid, input character, input negative, input base_error,
                    input last, output ready);
endinterface

FILE: hw/rtl/ritt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module ritt_ram #(
    parameter int WIDTH = 4,
    parameter int DEPTH = 64
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
            mem[waddr] <= wdata;
        rdata <= mem[raddr];
    end

endmodule

FILE: hw/rtl/radix_integer_to_text.sv
// Top level: microcoded integer-to-text converter, bases 2 to 16.
//
//  channel  | dir | payload                                      | handshake
//  operand  | in  | value[63:0], base[4:0], format_bits[1:0]     | valid/ready
//  text     | out | character[7:0], negative, base_error, last   | valid/ready
//
// A request runs CHECK, then per digit DIVI, DIVS over every dividend chunk and STORE,
// then READ, EMIT and LOOP per character, and DONE.
// The divider retires 8 dividend bits a cycle; READ covers the registered digit RAM read.
// A bad base runs CHECK, ERR and EXIT. Reset is asynchronous; no clearing pass is needed.
// Output stalls hold the sequencer in EMIT or ERR; the output register frees the next slot.
`timescale 1ns / 1ps

module radix_integer_to_text
    import ritt_pkg::*;
#(
    parameter int VALUE_BITS  = 64,
    parameter int DIGIT_DEPTH = 64
) (
    input  logic       clk,
    input  logic       rst_n,
    ritt_in_if.sink    operand,
    ritt_out_if.source text
);

    localparam int CHUNKS   = (VALUE_BITS + STEP_BITS - 1) / STEP_BITS;
    localparam int PAD_BITS = CHUNKS * STEP_BITS;
    localparam int CHUNK_W  = $clog2(CHUNKS + 1);
    localparam int COUNT_W  = $clog2(DIGIT_DEPTH + 1);
    localparam int AW       = $clog2(DIGIT_DEPTH);
    localparam logic [CHUNK_W-1:0] CHUNK_LAST = CHUNK_W'(CHUNKS - 1);
    localparam logic [COUNT_W-1:0] DEPTH_CNT  = COUNT_W'(DIGIT_DEPTH);

    logic [PC_W-1:0]       pc_reg, pc_next;
    ucode_t                uw;
    logic                  take;

    logic [PAD_BITS-1:0]   mag_reg, mag_next;
    logic [DIGIT_BITS-1:0] rem_reg, rem_next;
    logic [CHUNK_W-1:0]    chunk_reg, chunk_next;
    logic [COUNT_W-1:0]    count_reg, count_next;
    logic [COUNT_W-1:0]    k_reg, k_next;
    logic [4:0]            base_reg, base_next;
    logic [2:0]            flags_reg, flags_next;   // {negative, lower, unsigned}

    logic                  out_valid_reg, out_valid_next;
    logic [7:0]            out_char_reg, out_char_next;
    logic                  out_neg_reg, out_neg_next;
    logic                  out_err_reg, out_err_next;
    logic                  out_last_reg, out_last_next;

    logic                  accept;
    logic                  slot_free;
    logic [VALUE_BITS-1:0] in_v, in_abs;
    logic                  in_neg;
    logic [PAD_BITS-1:0]   div_q;
    logic [DIGIT_BITS-1:0] div_r;
    logic                  ram_we;
    logic [COUNT_W-1:0]    rd_idx;
    logic [DIGIT_BITS-1:0] ram_rdata;

    assign uw        = ucode(pc_reg);
    assign accept    = uw.accept && operand.valid;
    assign slot_free = !out_valid_reg || text.ready;
    assign ram_we    = uw.store && (count_reg < DEPTH_CNT);
    assign rd_idx    = count_reg - COUNT_W'(1) - k_reg;

    assign in_v   = operand.value[VALUE_BITS-1:0];
    assign in_neg = !operand.format_bits[0] && in_v[VALUE_BITS-1];
    assign in_abs = in_neg ? -in_v : in_v;

    // restoring division, STEP_BITS quotient bits per cycle
    always_comb
    begin
        logic [DIGIT_BITS:0] t;
        div_q = mag_reg;
        div_r = rem_reg;
        for (int i = 0; i < STEP_BITS; i++)
        begin
            t     = {div_r, div_q[PAD_BITS-1]};
            div_q = {div_q[PAD_BITS-2:0], 1'b0};
            if (t >= base_reg)
            begin
                t        = t - base_reg;
                div_q[0] = 1'b1;
            end
            div_r = t[DIGIT_BITS-1:0];
        end
    end

    always_comb
    begin
        case (uw.cond)
            COND_NEXT:      take = 1'b0;
            COND_ALWAYS:    take = 1'b1;
            COND_NO_REQ:    take = !operand.valid;
            COND_BAD_BASE:  take = (base_reg < BASE_MIN) || (base_reg > BASE_MAX);
            COND_DIV_MORE:  take = chunk_reg != CHUNK_LAST;
            COND_MAG_NZ:    take = mag_reg != '0;
            COND_SLOT_BUSY: take = !slot_free;
            COND_MORE_CHAR: take = k_reg != count_reg;
            default:        take = 1'b0;
        endcase
        pc_next = take ? uw.target : pc_reg + PC_W'(1);
    end

    always_comb
    begin
        mag_next   = mag_reg;
        rem_next   = rem_reg;
        chunk_next = chunk_reg;
        count_next = count_reg;
        k_next     = k_reg;
        base_next  = base_reg;
        flags_next = flags_reg;
        if (accept)
        begin
            mag_next   = PAD_BITS'(in_abs);
            base_next  = operand.base;
            flags_next = {in_neg, operand.format_bits};
            count_next = '0;
            k_next     = '0;
        end
        if (uw.div_init)
        begin
            rem_next   = '0;
            chunk_next = '0;
        end
        if (uw.div_step)
        begin
            mag_next   = div_q;
            rem_next   = div_r;
            chunk_next = chunk_reg + CHUNK_W'(1);
        end
        if (ram_we)
            count_next = count_reg + COUNT_W'(1);
        if (uw.emit && slot_free)
            k_next = k_reg + COUNT_W'(1);
        if (uw.err && slot_free)
        begin
            count_next = '0;
            flags_next = {1'b0, flags_reg[1:0]};
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && !text.ready;
        out_char_next  = out_char_reg;
        out_neg_next   = out_neg_reg;
        out_err_next   = out_err_reg;
        out_last_next  = out_last_reg;
        if (uw.emit && slot_free)
        begin
            out_valid_next = 1'b1;
            out_char_next  = digit_char(ram_rdata, flags_reg[1]);
            out_neg_next   = flags_reg[2];
            out_err_next   = 1'b0;
            out_last_next  = k_reg == count_reg - COUNT_W'(1);
        end
        else if (uw.err && slot_free)
        begin
            out_valid_next = 1'b1;
            out_char_next  = '0;
            out_neg_next   = 1'b0;
            out_err_next   = 1'b1;
            out_last_next  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pc_reg        <= ST_IDLE;
            chunk_reg     <= '0;
            count_reg     <= '0;
            k_reg         <= '0;
            base_reg      <= '0;
            flags_reg     <= '0;
            mag_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            pc_reg        <= pc_next;
            chunk_reg     <= chunk_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            base_reg      <= base_next;
            flags_reg     <= flags_next;
            mag_reg       <= mag_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg      <= rem_next;
        out_char_reg <= out_char_next;
        out_neg_reg  <= out_neg_next;
        out_err_reg  <= out_err_next;
        out_last_reg <= out_last_next;
    end

    ritt_ram #(
        .WIDTH (DIGIT_BITS),
        .DEPTH (DIGIT_DEPTH)
    ) u_digits (
        .clk   (clk),
        .we    (ram_we),
        .waddr (count_reg[AW-1:0]),
        .wdata (rem_reg),
        .raddr (rd_idx[AW-1:0]),
        .rdata (ram_rdata)
    );

    assign operand.ready   = uw.accept;
    assign text.valid      = out_valid_reg;
    assign text.character  = out_char_reg;
    assign text.negative   = out_neg_reg;
    assign text.base_error = out_err_reg;
    assign text.last       = out_last_reg;

    a_accept_to_check: assert property (@(posedge clk) disable iff (!rst_n)
        operand.valid && operand.ready |=> pc_reg == ST_CHECK)
        else $error("sequencer did not advance after request");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= DEPTH_CNT)
        else $error("digit count beyond store depth");

    a_emit_index: assert property (@(posedge clk) disable iff (!rst_n)
        pc_reg == ST_EMIT |-> k_reg < count_reg)
        else $error("emit index beyond digit count");

    a_error_result: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && text.base_error |-> text.last && !text.negative && text.character == '0)
        else $error("malformed base error result");

endmodule

FILE: tb/radix_integer_to_text_tb.sv
// Testbench for radix_integer_to_text: random and directed requests, scoreboarded text output.
`timescale 1ns / 1ps

module radix_integer_to_text_tb
    import ritt_pkg::*;
();

    localparam int DIGIT_LIMIT  = 64;
    localparam int FMT_UNSIGNED = 0;
    localparam int FMT_LOWER    = 1;
    localparam logic [8*16-1:0] UPPER_DIGITS = "0123456789ABCDEF";
    localparam logic [8*16-1:0] LOWER_DIGITS = "0123456789abcdef";
    localparam logic [63:0] MOST_NEGATIVE = 64'h8000_0000_0000_0000;
    localparam logic [63:0] MOST_POSITIVE = 64'h7FFF_FFFF_FFFF_FFFF;
    localparam logic [63:0] ALL_ONES      = 64'hFFFF_FFFF_FFFF_FFFF;

    typedef struct packed {
        logic [63:0] value;
        logic [4:0]  base;
        logic [1:0]  fmt;
    } operand_t;

    typedef struct packed {
        logic [7:0] character;
        logic       negative;
        logic       base_error;
        logic       last;
    } text_t;

    logic clk = 1'b0;
    logic rst_n;

    ritt_in_if  operand_ch();
    ritt_out_if text_ch();

    radix_integer_to_text dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .operand (operand_ch),
        .text    (text_ch)
    );

    always #4 clk = ~clk;

    operand_t pending_operands[$];
    text_t    expected_text[$];
    operand_t next_operand;
    text_t    got_text;
    text_t    want_text;
    int       send_idle_pct;
    int       recv_stall_pct;
    int       mismatch_count = 0;

    function automatic void predict_text(input operand_t op);
        logic [63:0]     mag;
        logic [3:0]      digits[$];
        logic [8*16-1:0] digit_set;
        logic            neg;
        text_t           r;
        int              k;
        if (op.base < BASE_MIN || op.base > BASE_MAX)
        begin
            r = '{character: 8'd0, negative: 1'b0, base_error: 1'b1, last: 1'b1};
            expected_text.push_back(r);
            return;
        end
        neg = !op.fmt[FMT_UNSIGNED] && op.value[63];
        mag = neg ? -op.value : op.value;
        do
        begin
            if (digits.size() < DIGIT_LIMIT)
                digits.push_back(4'(mag % op.base));
            mag = mag / op.base;
        end while (mag != 0);
        digit_set = op.fmt[FMT_LOWER] ? LOWER_DIGITS : UPPER_DIGITS;
        for (k = digits.size() - 1; k >= 0; k--)
        begin
            r.character  = digit_set[8 * (15 - digits[k]) +: 8];
            r.negative   = neg;
            r.base_error = 1'b0;
            r.last       = (k == 0);
            expected_text.push_back(r);
        end
    endfunction

    function automatic operand_t random_operand();
        operand_t op;
        int       kind;
        kind = $urandom_range(9);
        if (kind == 0)
            op.value = 64'd0;
        else if (kind <= 3)
        begin
            op.value = 64'($urandom_range(5000));
            if ($urandom_range(1))
                op.value = -op.value;
        end
        else if (kind == 4)
        begin
            case ($urandom_range(3))
                0: op.value = MOST_NEGATIVE;
                1: op.value = MOST_POSITIVE;
                2: op.value = ALL_ONES;
                default: op.value = 64'd1;
            endcase
        end
        else
            op.value = {$urandom, $urandom};
        if ($urandom_range(9) == 0)
            op.base = $urandom_range(1) ? 5'($urandom_range(1)) : 5'($urandom_range(31, 17));
        else
            op.base = 5'($urandom_range(16, 2));
        op.fmt = 2'($urandom_range(3));
        return op;
    endfunction

    task automatic add_operand(input logic [63:0] value, input logic [4:0] base,
                               input logic [1:0] fmt);
        pending_operands.push_back('{value: value, base: base, fmt: fmt});
    endtask

    // main thread waits here until every request is taken and all text is back
    task automatic drain();
        while (pending_operands.size() != 0 || operand_ch.valid || expected_text.size() != 0)
            @(negedge clk);
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        @(negedge clk);
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (count)
            pending_operands.push_back(random_operand());
        drain();
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            operand_ch.valid       <= 1'b0;
            operand_ch.value       <= '0;
            operand_ch.base        <= '0;
            operand_ch.format_bits <= '0;
        end
        else
        begin
            if (operand_ch.valid && operand_ch.ready)
                predict_text({operand_ch.value, operand_ch.base, operand_ch.format_bits});
            if (!operand_ch.valid || operand_ch.ready)
            begin
                if (pending_operands.size() != 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    next_operand = pending_operands.pop_front();
                    operand_ch.valid       <= 1'b1;
                    operand_ch.value       <= next_operand.value;
                    operand_ch.base        <= next_operand.base;
                    operand_ch.format_bits <= next_operand.fmt;
                end
                else
                    operand_ch.valid <= 1'b0;
            end
        end
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            text_ch.ready <= 1'b0;
        else
        begin
            if (text_ch.valid && text_ch.ready)
            begin
                got_text = {text_ch.character, text_ch.negative, text_ch.base_error,
                            text_ch.last};
                if (expected_text.size() == 0)
                begin
                    $display("%0t: unexpected text char=%h neg=%b err=%b last=%b", $time,
                             got_text.character, got_text.negative, got_text.base_error,
                             got_text.last);
                    mismatch_count++;
                end
                else
                begin
                    want_text = expected_text.pop_front();
                    if (got_text !== want_text)
                    begin
                        $display("%0t: text mismatch exp char=%h neg=%b err=%b last=%b",
                                 $time, want_text.character, want_text.negative,
                                 want_text.base_error, want_text.last);
                        $display("%0t:               got char=%h neg=%b err=%b last=%b",
                                 $time, got_text.character, got_text.negative,
                                 got_text.base_error, got_text.last);
                        mismatch_count++;
                    end
                end
            end
            text_ch.ready <= ($urandom_range(99) >= recv_stall_pct);
        end
    end

    initial
    begin
        #16_000_000;
        $display("== FAIL ==");
        $finish;
    end

    initial
    begin
        send_idle_pct          = 0;
        recv_stall_pct         = 0;
        rst_n                  = 1'b0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        @(negedge clk);
        add_operand(64'd0, 5'd10, 2'b00);
        add_operand(64'd0, 5'd2, 2'b01);
        add_operand(MOST_POSITIVE, 5'd10, 2'b00);
        add_operand(MOST_NEGATIVE, 5'd10, 2'b00);
        add_operand(MOST_NEGATIVE, 5'd2, 2'b00);
        add_operand(MOST_NEGATIVE, 5'd16, 2'b10);
        add_operand(ALL_ONES, 5'd2, 2'b01);
        add_operand(ALL_ONES, 5'd16, 2'b01);
        add_operand(ALL_ONES, 5'd16, 2'b11);
        add_operand(ALL_ONES, 5'd10, 2'b00);
        add_operand(-64'd255, 5'd16, 2'b10);
        add_operand(-64'd255, 5'd16, 2'b00);
        add_operand(64'h0000_0000_00AB_CDEF, 5'd16, 2'b00);
        add_operand(64'h0000_0000_00AB_CDEF, 5'd16, 2'b10);
        add_operand(64'd1000, 5'd3, 2'b00);
        add_operand(-64'd4242, 5'd7, 2'b00);
        add_operand(64'd123456789, 5'd15, 2'b10);
        add_operand(64'd1, 5'd13, 2'b01);
        add_operand(64'd12345, 5'd0, 2'b00);
        add_operand(-64'd12345, 5'd1, 2'b00);
        add_operand(64'd12345, 5'd17, 2'b11);
        add_operand(ALL_ONES, 5'd31, 2'b10);
        drain();

        run_phase(0, 0, 20);
        run_phase(71, 0, 20);
        run_phase(0, 71, 20);
        run_phase(10, 10, 20);

        repeat (40) @(posedge clk);
        if (mismatch_count == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule
